// File: rtl/splc_pkg.sv
`default_nettype none

package splc_pkg;

  // Wave memory geometry
  localparam int WAVE_DEPTH = 65536;
  localparam int ADDR_W     = $clog2(WAVE_DEPTH);
  localparam int POS_W      = ADDR_W + 1;

  // Request kinds
  typedef enum logic [1:0] {
    ACT_FRAME = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_START = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_GAIN    = 2'd0,
    REG_WAVELEN = 2'd1,
    REG_OVERLAP = 2'd2,
    REG_UNUSED  = 2'd3
  } reg_idx_t;

  // Register reset values
  localparam logic [15:0] GAIN_RST    = 16'd3277;
  localparam logic [16:0] WAVELEN_RST = 17'd65536;
  localparam logic [15:0] OVERLAP_RST = 16'd48000;

  typedef struct packed {
    logic [1:0]          action;
    logic [15:0]         address;
    logic signed [15:0]  sample_left;
    logic signed [15:0]  sample_right;
    logic                loop_enable;
    logic signed [23:0]  mix_left;
    logic signed [23:0]  mix_right;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0]  out_left;
    logic signed [23:0]  out_right;
    logic                active;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/sample_player_loop_crossfade_unit.sv
`default_nettype none

// Stereo wave player that mixes one scaled wave frame into each incoming mix
// request. Load and start requests do not stall the input. A frame request
// while stopped passes the mix pair unchanged through the result stage into
// the output register. A playing frame runs through a small sequencer around
// one shared 17x17 multiplier: a prepare step and two read steps fetch the tail
// and head samples over the single memory read port, then per channel two
// weighting products, a magnitude step, two partial gain products, a rounding
// step and an accumulate step, plus a result stage to hand the result over,
// with the input stalled throughout. In the crossfade region each channel also
// goes through a one-bit-per-cycle divider by the overlap length (17 steps).
// A finished result waits in the output register, and the next request is
// taken meanwhile; a result that finds the output register still full holds
// the sequencer until it drains. The wave memory has no reset; only entries
// that were loaded may be played.
module sample_player_loop_crossfade_unit (
  input  wire                  clk,
  input  wire                  rst_n,
  // request channel
  input  wire                  in_valid,
  output logic                 in_stall,
  input  splc_pkg::in_item_t   in_data,
  // result channel
  output logic                 out_valid,
  input  wire                  out_stall,
  output splc_pkg::out_item_t  out_data,
  // register port
  input  wire                  cfg_psel,
  input  wire                  cfg_penable,
  input  wire                  cfg_pwrite,
  input  wire  [3:0]           cfg_paddr,
  input  wire  [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  localparam int AW  = splc_pkg::ADDR_W;
  localparam int PW  = splc_pkg::POS_W;
  localparam int QW  = 17;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_RD1, S_RD2, S_W0, S_W1, S_MAG,
    S_G0, S_G1, S_RND, S_DIV, S_ACC, S_FIN
  } state_t;

  state_t state_r;

  // configuration registers
  logic [15:0] gain_r;
  logic [16:0] wave_length_r;
  logic [15:0] overlap_r;

  // playback state
  logic [PW-1:0] rp_r, fp_r;
  logic          playing_r, looping_r;

  // per-frame working registers
  logic                run_r, fade_r, ch_r, neg_r;
  logic [15:0]         rest_r, k_r;
  logic [31:0]         tail_r, head_r;
  logic signed [23:0]  mix_l_r, mix_r_r;
  logic signed [33:0]  x_r;
  logic [30:0]         mag_r;
  logic [46:0]         p_r;
  logic [15:0]         rem_r;
  logic [QW-1:0]       dq_r;
  logic [4:0]          cnt_r;
  logic signed [23:0]  res_l_r, res_r_r;

  // output register
  logic                 out_valid_r;
  splc_pkg::out_item_t  out_data_r;

  // wave memory
  logic [31:0]   mem [splc_pkg::WAVE_DEPTH];
  logic [31:0]   mem_q_r;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  logic in_acc;
  logic cfg_we;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_pready = 1'b1;
  assign cfg_we    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign mem_we    = in_acc && (in_data.action == splc_pkg::ACT_LOAD);

  // register write and read back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r        <= splc_pkg::GAIN_RST;
      wave_length_r <= splc_pkg::WAVELEN_RST;
      overlap_r     <= splc_pkg::OVERLAP_RST;
    end else if (cfg_we) begin
      unique case (splc_pkg::reg_idx_t'(cfg_paddr[3:2]))
        splc_pkg::REG_GAIN:    gain_r        <= cfg_pwdata[15:0];
        splc_pkg::REG_WAVELEN: wave_length_r <= cfg_pwdata[16:0];
        splc_pkg::REG_OVERLAP: overlap_r     <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (splc_pkg::reg_idx_t'(cfg_paddr[3:2]))
      splc_pkg::REG_GAIN:    cfg_prdata = {16'd0, gain_r};
      splc_pkg::REG_WAVELEN: cfg_prdata = {15'd0, wave_length_r};
      splc_pkg::REG_OVERLAP: cfg_prdata = {16'd0, overlap_r};
      default:               cfg_prdata = 32'd0;
    endcase
  end

  // effective wave length, clamped to 1..depth
  logic [PW-1:0] len_c;
  always_comb begin
    if (wave_length_r == 17'd0)
      len_c = PW'(1);
    else if (32'(wave_length_r) > 32'(splc_pkg::WAVE_DEPTH))
      len_c = PW'(splc_pkg::WAVE_DEPTH);
    else
      len_c = PW'(wave_length_r);
  end

  // position wrap and mode decision at frame start
  logic [PW-1:0] rp_n, fp_n;
  logic [31:0]   fp_w, ov_w, len_w;
  logic          fade_c;
  logic [15:0]   k_c;
  assign rp_n  = (rp_r >= len_c) ? '0 : rp_r;
  assign fp_n  = (fp_r >= len_c) ? '0 : fp_r;
  assign fp_w  = 32'(fp_n);
  assign ov_w  = 32'(overlap_r);
  assign len_w = 32'(len_c);
  assign fade_c = looping_r && (ov_w < len_w) && (32'(rp_n) >= (len_w - ov_w));
  assign k_c    = (fp_w < ov_w) ? fp_w[15:0] : overlap_r;

  // memory: tail at read position, then head at fade position
  assign rd_addr = (state_r == S_PREP) ? rp_n[AW-1:0] : fp_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we)
      mem[AW'(in_data.address)] <= {in_data.sample_right, in_data.sample_left};
    mem_q_r <= mem[rd_addr];
  end

  // shared multiplier
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] mul_p;
  logic [15:0]        tail_s, head_s;
  assign tail_s = ch_r ? tail_r[31:16] : tail_r[15:0];
  assign head_s = ch_r ? head_r[31:16] : head_r[15:0];

  always_comb begin
    case (state_r)
      S_W0: begin
        mul_a = {tail_s[15], tail_s};
        mul_b = {1'b0, rest_r};
      end
      S_W1: begin
        mul_a = {head_s[15], head_s};
        mul_b = {1'b0, k_r};
      end
      S_G0: begin
        mul_a = {1'b0, mag_r[15:0]};
        mul_b = {1'b0, gain_r};
      end
      S_G1: begin
        mul_a = {2'b0, mag_r[30:16]};
        mul_b = {1'b0, gain_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // magnitude of the weighted sum
  logic signed [33:0] x_abs;
  assign x_abs = x_r[33] ? -x_r : x_r;

  // rounding offset: half the divisor, divisor is overlap (crossfade) or 1
  logic [15:0] div_c;
  logic [47:0] rnd_sum;
  logic [32:0] d_c;
  assign div_c   = fade_r ? overlap_r : 16'd1;
  assign rnd_sum = {1'b0, p_r} + {18'd0, div_c, 14'd0};
  assign d_c     = rnd_sum[47:15];

  // divider step
  logic [16:0] trial;
  logic        q_bit;
  logic [16:0] trial_sub;
  assign trial     = {rem_r, dq_r[QW-1]};
  assign q_bit     = (trial >= {1'b0, overlap_r});
  assign trial_sub = trial - {1'b0, overlap_r};

  // signed add and saturation
  logic signed [17:0] add_c;
  logic signed [23:0] mix_c;
  logic signed [24:0] sum_c;
  logic signed [23:0] sat_c;
  assign add_c = neg_r ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});
  assign mix_c = ch_r ? mix_r_r : mix_l_r;
  assign sum_c = 25'(mix_c) + 25'(add_c);
  always_comb begin
    if (sum_c > 25'sd8388607)
      sat_c = 24'sh7FFFFF;
    else if (sum_c < -25'sd8388608)
      sat_c = 24'sh800000;
    else
      sat_c = sum_c[23:0];
  end

  // position advance after a playing frame
  logic [PW-1:0] rp1, fp1;
  assign rp1 = rp_r + PW'(1);
  assign fp1 = fp_r + PW'(1);

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      playing_r   <= 1'b0;
      looping_r   <= 1'b0;
      rp_r        <= '0;
      fp_r        <= '0;
      run_r       <= 1'b0;
      fade_r      <= 1'b0;
      ch_r        <= 1'b0;
      cnt_r       <= '0;
    end else begin
      // result taken and nothing new to hand over
      if (out_valid_r && !out_stall && (state_r != S_FIN))
        out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_data.action)
              splc_pkg::ACT_START: begin
                if (!playing_r) begin
                  playing_r <= 1'b1;
                  looping_r <= in_data.loop_enable;
                  rp_r      <= '0;
                  fp_r      <= '0;
                end
              end
              splc_pkg::ACT_FRAME: begin
                mix_l_r <= in_data.mix_left;
                mix_r_r <= in_data.mix_right;
                run_r   <= playing_r;
                if (playing_r) begin
                  state_r <= S_PREP;
                end else begin
                  res_l_r <= in_data.mix_left;
                  res_r_r <= in_data.mix_right;
                  state_r <= S_FIN;
                end
              end
              default: ;
            endcase
          end
        end
        S_PREP: begin
          rp_r   <= rp_n;
          fp_r   <= fp_n;
          fade_r <= fade_c;
          rest_r <= fade_c ? (overlap_r - k_c) : 16'd1;
          k_r    <= fade_c ? k_c : 16'd0;
          ch_r   <= 1'b0;
          state_r <= S_RD1;
        end
        S_RD1: begin
          tail_r  <= mem_q_r;
          state_r <= S_RD2;
        end
        S_RD2: begin
          head_r  <= fade_r ? mem_q_r : 32'd0;
          state_r <= S_W0;
        end
        S_W0: begin
          x_r     <= mul_p;
          state_r <= S_W1;
        end
        S_W1: begin
          x_r     <= x_r + mul_p;
          state_r <= S_MAG;
        end
        S_MAG: begin
          neg_r   <= x_r[33];
          mag_r   <= x_abs[30:0];
          state_r <= S_G0;
        end
        S_G0: begin
          p_r     <= {15'd0, mul_p[31:0]};
          state_r <= S_G1;
        end
        S_G1: begin
          p_r     <= p_r + {mul_p[30:0], 16'd0};
          state_r <= S_RND;
        end
        S_RND: begin
          dq_r <= d_c[QW-1:0];
          if (fade_r) begin
            rem_r   <= d_c[32:QW];
            cnt_r   <= '0;
            state_r <= S_DIV;
          end else begin
            state_r <= S_ACC;
          end
        end
        S_DIV: begin
          rem_r <= q_bit ? trial_sub[15:0] : trial[15:0];
          dq_r  <= {dq_r[QW-2:0], q_bit};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(QW - 1))
            state_r <= S_ACC;
        end
        S_ACC: begin
          if (ch_r) begin
            res_r_r <= sat_c;
            state_r <= S_FIN;
          end else begin
            res_l_r <= sat_c;
            ch_r    <= 1'b1;
            state_r <= S_W0;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r         <= 1'b1;
            out_data_r.out_left  <= res_l_r;
            out_data_r.out_right <= res_r_r;
            // a one-shot that reaches the end reports stopped
            out_data_r.active    <= playing_r &&
                                    !(run_r && !looping_r && (rp1 >= len_c));
            if (run_r) begin
              if (!looping_r) begin
                if (rp1 >= len_c) begin
                  rp_r <= '0;
                  playing_r <= 1'b0;
                end else begin
                  rp_r <= rp1;
                end
              end else if (!fade_r) begin
                fp_r <= '0;
                rp_r <= (rp1 >= len_c) ? '0 : rp1;
              end else if (rp1 >= len_c) begin
                if (fp1 >= len_c) begin
                  rp_r <= '0;
                  fp_r <= '0;
                end else begin
                  rp_r <= fp1;
                  fp_r <= fp1;
                end
              end else begin
                rp_r <= rp1;
                fp_r <= fp1;
              end
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // divider remainder stays below the overlap length
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < overlap_r))
    else $error("divider remainder out of range");

  // a frame while stopped goes straight to the result stage
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_data.action == splc_pkg::ACT_FRAME) && !playing_r)
      |=> (state_r == S_FIN))
    else $error("stopped frame did not bypass the datapath");

  // the divider only hands over to the accumulate step
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |=> ((state_r == S_DIV) || (state_r == S_ACC)))
    else $error("divider left early");

  // the divider is used for crossfade frames only
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> fade_r)
    else $error("divider entered outside the crossfade");

endmodule

`default_nettype wire
